// File: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam logic [1:0] FUNC_ALLOC      = 2'd0;
  localparam logic [1:0] FUNC_FREE       = 2'd1;
  localparam logic [1:0] FUNC_RANGE_FREE = 2'd2;
  localparam logic [1:0] FUNC_RANGE_USED = 2'd3;

  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_CLEAR,
    OP_SET,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic raise_hw;
  } cmd_ctl_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RREAD,
    ST_RMOD,
    ST_AREAD,
    ST_ACHK,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/bfa_front.sv
// ----------------------------------------------------------------------------
// bfa_front
// Decodes commands into clipped frame ranges and queues them for the back end.
// ----------------------------------------------------------------------------
module bfa_front #(
  parameter int NUM_FRAMES  = 65536,
  parameter int FRAME_BYTES = 4096,
  parameter int FW          = $clog2(NUM_FRAMES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [31:0]         base_address,
  input  logic [31:0]         length,
  input  logic                init_busy,
  output logic                q_valid,
  input  logic                q_pop,
  output bfa_pkg::cmd_ctl_t   q_ctl,
  output logic [FW-1:0]       q_first,
  output logic [FW-1:0]       q_last
);
  import bfa_pkg::*;

  localparam int S = $clog2(FRAME_BYTES);
  localparam logic [33:0] FBM1 = 34'(FRAME_BYTES - 1);
  localparam logic [33:0] NF34 = 34'(NUM_FRAMES);

  logic [33:0] b34, e34, first_w, last_w, last_c;
  logic        nonempty, push;
  cmd_ctl_t    ctl_d;
  logic [FW-1:0] first_d, last_d;

  cmd_ctl_t      ctl_q   [2];
  logic [FW-1:0] first_q [2];
  logic [FW-1:0] last_q  [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  always_comb begin
    b34 = {2'b00, base_address};
    e34 = b34 + {2'b00, length};
    case (func)
      FUNC_RANGE_FREE: begin
        first_w = (b34 + FBM1) >> S;
        last_w  = e34 >> S;
      end
      FUNC_RANGE_USED: begin
        first_w = b34 >> S;
        last_w  = (e34 + FBM1) >> S;
      end
      default: begin
        first_w = b34 >> S;
        last_w  = (b34 >> S) + 34'd1;
      end
    endcase
    last_c   = (last_w > NF34) ? NF34 : last_w;
    nonempty = first_w < last_c;
    first_d  = FW'(first_w);
    last_d   = FW'(last_c);
    ctl_d.raise_hw = (func == FUNC_RANGE_FREE);
    case (func)
      FUNC_ALLOC:      ctl_d.op = OP_ALLOC;
      FUNC_RANGE_USED: ctl_d.op = nonempty ? OP_SET : OP_NONE;
      default:         ctl_d.op = nonempty ? OP_CLEAR : OP_NONE;
    endcase
  end

  assign in_stall = (count == 2'd2) || init_busy;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_ctl    = ctl_q[rd_ptr];
  assign q_first  = first_q[rd_ptr];
  assign q_last   = last_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr]   <= ctl_d;
      first_q[wr_ptr] <= first_d;
      last_q[wr_ptr]  <= last_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: rtl/bfa_back.sv
// ----------------------------------------------------------------------------
// bfa_back
// Executes queued commands on the frame bitmap memory, word by word.
// ----------------------------------------------------------------------------
module bfa_back #(
  parameter int NUM_FRAMES  = 65536,
  parameter int FRAME_BYTES = 4096,
  parameter int FW          = $clog2(NUM_FRAMES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  output logic                init_busy,
  input  logic                q_valid,
  output logic                q_pop,
  input  bfa_pkg::cmd_ctl_t   q_ctl,
  input  logic [FW-1:0]       q_first,
  input  logic [FW-1:0]       q_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         frame_address,
  output logic                out_of_memory,
  output logic [16:0]         frame_count
);
  import bfa_pkg::*;

  localparam int S          = $clog2(FRAME_BYTES);
  localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [WIW-1:0] LAST_WORD = WIW'(WORD_COUNT - 1);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data, wdata;
  logic                 we;

  state_t state, state_next;
  logic [WIW-1:0] w, w_next, fw, fw_next, lw, lw_next;
  logic [BIT_IDX_W-1:0] lo, lo_next, hi, hi_next;
  logic set_op, set_op_next;
  logic [FW-1:0] hw, hw_next;
  logic [31:0] res_addr, res_addr_next;
  logic res_oom, res_oom_next;
  logic out_valid_next;
  logic [31:0] fa_next;
  logic oom_next;
  logic [16:0] fc_next;

  logic [FW-1:0] lastm1, hwm1, alloc_frame;
  logic [WORD_BITS-1:0] mask, avail, onehot;
  logic [BIT_IDX_W-1:0] lo_e, hi_e, hit_idx;
  logic hit;
  logic [FW+S-1:0] alloc_byte;

  always_ff @(posedge clk) begin
    if (we) mem[w] <= wdata;
    rd_data <= mem[w];
  end

  assign init_busy = (state == ST_INIT);

  always_comb begin
    state_next     = state;
    w_next         = w;
    fw_next        = fw;
    lw_next        = lw;
    lo_next        = lo;
    hi_next        = hi;
    set_op_next    = set_op;
    hw_next        = hw;
    res_addr_next  = res_addr;
    res_oom_next   = res_oom;
    out_valid_next = out_valid && out_stall;
    fa_next        = frame_address;
    oom_next       = out_of_memory;
    fc_next        = frame_count;
    q_pop          = 1'b0;
    we             = 1'b0;
    wdata          = '1;

    lastm1 = q_last - FW'(1);
    hwm1   = hw - FW'(1);

    lo_e = (w == fw) ? lo : '0;
    hi_e = (w == lw) ? hi : '1;
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (BIT_IDX_W'(j) >= lo_e) && (BIT_IDX_W'(j) <= hi_e);
    end

    avail   = ~rd_data & mask;
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        hit     = 1'b1;
        hit_idx = BIT_IDX_W'(j);
      end
    end
    onehot      = WORD_BITS'(1) << hit_idx;
    alloc_frame = FW'({w, hit_idx});
    alloc_byte  = {alloc_frame, {S{1'b0}}};

    case (state)
      ST_INIT: begin
        we = 1'b1;
        if (w == LAST_WORD) begin
          state_next = ST_IDLE;
          w_next     = '0;
        end else begin
          w_next = w + WIW'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          res_addr_next = '0;
          res_oom_next  = 1'b0;
          case (q_ctl.op)
            OP_ALLOC: begin
              if (hw == '0) begin
                res_oom_next = 1'b1;
                state_next   = ST_RESULT;
              end else begin
                w_next     = '0;
                fw_next    = '0;
                lo_next    = '0;
                lw_next    = WIW'(hwm1 >> BIT_IDX_W);
                hi_next    = hwm1[BIT_IDX_W-1:0];
                state_next = ST_AREAD;
              end
            end
            OP_CLEAR, OP_SET: begin
              set_op_next = (q_ctl.op == OP_SET);
              w_next      = WIW'(q_first >> BIT_IDX_W);
              fw_next     = WIW'(q_first >> BIT_IDX_W);
              lo_next     = q_first[BIT_IDX_W-1:0];
              lw_next     = WIW'(lastm1 >> BIT_IDX_W);
              hi_next     = lastm1[BIT_IDX_W-1:0];
              if (q_ctl.raise_hw && q_last > hw) hw_next = q_last;
              state_next  = ST_RREAD;
            end
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_RREAD: state_next = ST_RMOD;
      ST_RMOD: begin
        we    = 1'b1;
        wdata = set_op ? (rd_data | mask) : (rd_data & ~mask);
        if (w == lw) begin
          state_next = ST_RESULT;
        end else begin
          w_next     = w + WIW'(1);
          state_next = ST_RREAD;
        end
      end
      ST_AREAD: state_next = ST_ACHK;
      ST_ACHK: begin
        if (hit) begin
          we            = 1'b1;
          wdata         = rd_data | onehot;
          res_addr_next = 32'(alloc_byte);
          state_next    = ST_RESULT;
        end else if (w == lw) begin
          res_oom_next = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          w_next     = w + WIW'(1);
          state_next = ST_AREAD;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          fa_next        = res_addr;
          oom_next       = res_oom;
          fc_next        = 17'(hw);
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      w         <= '0;
      hw        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      w         <= w_next;
      hw        <= hw_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fw            <= fw_next;
    lw            <= lw_next;
    lo            <= lo_next;
    hi            <= hi_next;
    set_op        <= set_op_next;
    res_addr      <= res_addr_next;
    res_oom       <= res_oom_next;
    frame_address <= fa_next;
    out_of_memory <= oom_next;
    frame_count   <= fc_next;
  end

endmodule

// File: rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit bitmap page frame allocator with range marking.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is filled with ones, word by word, with
// in_stall held high. Each command then yields one result. The bitmap sits
// in a single-port memory with registered read, so each 32-frame word is read
// and then checked or written back: an alloc scans up to ceil(high_water/32)
// words, a range mark rewrites each word touched, a free rewrites one word,
// and an empty range or an alloc with a zero high-water count goes straight to
// the result. A two-entry command queue lets decoding run ahead of the bitmap
// engine.
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES  = 65536,
  parameter int FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] base_address,
  input  logic [31:0] length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frame_address,
  output logic        out_of_memory,
  output logic [16:0] frame_count
);
  import bfa_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES + 1);

  logic          init_busy, q_valid, q_pop;
  cmd_ctl_t      q_ctl;
  logic [FW-1:0] q_first, q_last;

  bfa_front #(.NUM_FRAMES(NUM_FRAMES), .FRAME_BYTES(FRAME_BYTES), .FW(FW)) u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .base_address, .length,
    .init_busy, .q_valid, .q_pop, .q_ctl, .q_first, .q_last
  );

  bfa_back #(.NUM_FRAMES(NUM_FRAMES), .FRAME_BYTES(FRAME_BYTES), .FW(FW)) u_back (
    .clk, .rst, .init_busy, .q_valid, .q_pop, .q_ctl, .q_first, .q_last,
    .out_valid, .out_stall, .frame_address, .out_of_memory, .frame_count
  );

endmodule

// File: rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the bitmap frame allocator.
// ----------------------------------------------------------------------------
module bfa_checker #(
  parameter int FRAME_BYTES = 4096
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] frame_address,
  input logic        out_of_memory,
  input logic [16:0] frame_count
);

  localparam int S = $clog2(FRAME_BYTES);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_oom_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_memory |-> frame_address == 32'd0)
    else $error("out of memory with non-zero address");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_address[S-1:0] == '0)
    else $error("frame address not aligned");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_address)
      && $stable(out_of_memory) && $stable(frame_count))
    else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker #(.FRAME_BYTES(FRAME_BYTES)) u_bfa_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap frame allocator. Commands are queued up
// front and each expected result is worked out as it is queued, by a local
// model of the frame bitmap and the high-water count. A driver feeds the
// commands with random gaps, and a monitor compares every result transfer in
// order while the receive side stalls at random, with one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  localparam int N_FRAMES   = 65536;
  localparam int N_WORDS    = N_FRAMES / 32;
  localparam int PAGE_SHIFT = 12;
  localparam int BIG_COST   = 300;
  localparam int BIG_LIMIT  = 50;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] base;
    logic [31:0] len;
  } frame_cmd_t;

  typedef struct {
    logic [31:0] addr;
    logic        oom;
    logic [16:0] count;
  } frame_rsp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [31:0] base_address;
  logic [31:0] length;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] frame_address;
  logic        out_of_memory;
  logic [16:0] frame_count;

  logic [31:0] used_map [N_WORDS];
  logic [16:0] water_mark;

  frame_cmd_t cmd_q[$];
  frame_rsp_t rsp_q[$];
  frame_cmd_t drv_cmd;
  frame_rsp_t mon_rsp;

  logic in_fire;
  logic out_fire;
  int   gap_cnt;
  int   stall_cnt;
  int   hold_cnt;
  bit   held;
  int   n_err;
  int   n_rsp;
  int   n_alloc;
  int   n_oom;
  int   n_free;
  int   n_range;
  int   n_big;

  bitmap_frame_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .base_address  (base_address),
    .length        (length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_address (frame_address),
    .out_of_memory (out_of_memory),
    .frame_count   (frame_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int first_free(int limit);
    for (int w = 0; w * 32 < limit; w++) begin
      if (used_map[w] != '1) begin
        for (int b = 0; b < 32; b++) begin
          if (!used_map[w][b]) return (w * 32 + b < limit) ? w * 32 + b : -1;
        end
      end
    end
    return -1;
  endfunction

  function automatic int alloc_limit();
    return (int'(water_mark) > N_FRAMES) ? N_FRAMES : int'(water_mark);
  endfunction

  function automatic void frame_span(input frame_cmd_t c, output int lo, output int hi);
    logic [33:0] a;
    logic [33:0] z;
    if (c.func == FUNC_RANGE_FREE) begin
      a = {2'b00, c.base} + 34'd4095;
      z = {2'b00, c.base} + {2'b00, c.len};
    end else begin
      a = {2'b00, c.base};
      z = {2'b00, c.base} + {2'b00, c.len} + 34'd4095;
    end
    lo = int'(a >> PAGE_SHIFT);
    hi = int'(z >> PAGE_SHIFT);
    if (hi > N_FRAMES) hi = N_FRAMES;
  endfunction

  function automatic int op_cost(frame_cmd_t c);
    int lo;
    int hi;
    int f;
    if (c.func == FUNC_ALLOC) begin
      f = first_free(alloc_limit());
      return (f < 0) ? 2 * ((alloc_limit() + 31) / 32) : 2 * (f / 32 + 1);
    end
    if (c.func == FUNC_FREE) return 5;
    frame_span(c, lo, hi);
    if (lo >= hi) return 3;
    return 2 * ((hi - 1) / 32 - lo / 32 + 1);
  endfunction

  function automatic frame_rsp_t apply_cmd(frame_cmd_t c);
    frame_rsp_t r;
    int f;
    int lo;
    int hi;
    r.addr = '0;
    r.oom  = 1'b0;
    case (c.func)
      FUNC_ALLOC: begin
        f = first_free(alloc_limit());
        if (f < 0) begin
          r.oom = 1'b1;
        end else begin
          used_map[f / 32][f % 32] = 1'b1;
          r.addr = 32'(f) << PAGE_SHIFT;
        end
      end
      FUNC_FREE: begin
        f = int'(c.base >> PAGE_SHIFT);
        if (f < N_FRAMES) used_map[f / 32][f % 32] = 1'b0;
      end
      FUNC_RANGE_FREE: begin
        frame_span(c, lo, hi);
        for (int i = lo; i < hi; i++) used_map[i / 32][i % 32] = 1'b0;
        if (lo < hi && hi > int'(water_mark)) water_mark = 17'(hi);
      end
      default: begin
        frame_span(c, lo, hi);
        for (int i = lo; i < hi; i++) used_map[i / 32][i % 32] = 1'b1;
      end
    endcase
    r.count = water_mark;
    return r;
  endfunction

  task automatic push_cmd(logic [1:0] f, logic [31:0] b, logic [31:0] l);
    frame_cmd_t c;
    frame_rsp_t r;
    c.func = f;
    c.base = b;
    c.len  = l;
    if (op_cost(c) > BIG_COST) n_big++;
    r = apply_cmd(c);
    if (f == FUNC_ALLOC) n_alloc++;
    if (f == FUNC_FREE) n_free++;
    if (f == FUNC_RANGE_FREE || f == FUNC_RANGE_USED) n_range++;
    if (r.oom) n_oom++;
    cmd_q.push_back(c);
    rsp_q.push_back(r);
  endtask

  function automatic logic [31:0] low_addr();
    logic [31:0] a;
    a = 32'($urandom_range(0, 511)) << PAGE_SHIFT;
    if ($urandom_range(0, 3) == 0) a = a | 32'($urandom_range(0, 4095));
    return a;
  endfunction

  function automatic frame_cmd_t rand_cmd();
    frame_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.base = low_addr();
    c.len  = $urandom;
    if (sel < 40) begin
      c.func = FUNC_ALLOC;
      c.base = $urandom;
    end else if (sel < 60) begin
      c.func = FUNC_FREE;
      if ($urandom_range(0, 9) == 0) c.base = $urandom;
    end else if (sel < 80) begin
      c.func = FUNC_RANGE_FREE;
      c.len  = 32'($urandom_range(0, 65536));
    end else if (sel < 97) begin
      c.func = FUNC_RANGE_USED;
      c.len  = 32'($urandom_range(0, 32768));
    end else if (sel < 99) begin
      c.func = ($urandom_range(0, 1) == 0) ? FUNC_RANGE_FREE : FUNC_RANGE_USED;
      c.base = $urandom;
    end else begin
      c.func = FUNC_RANGE_USED;
      c.base = '0;
      c.len  = '1;
    end
    return c;
  endfunction

  // input side
  always @(posedge clk) begin
    in_fire  <= !rst && in_valid && !in_stall;
    out_fire <= !rst && out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
    end else if (gap_cnt > 0) begin
      in_valid <= 1'b0;
      gap_cnt  <= gap_cnt - 1;
    end else if (cmd_q.size() > 0) begin
      drv_cmd      = cmd_q.pop_front();
      func         <= drv_cmd.func;
      base_address <= drv_cmd.base;
      length       <= drv_cmd.len;
      in_valid     <= 1'b1;
      gap_cnt      <= ((n_rsp % 300) < 60) ? 0 : $urandom_range(0, 5);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output side
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (n_rsp == 400 && !held) begin
      held      <= 1'b1;
      hold_cnt  <= 500;
      out_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      out_stall <= 1'b1;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_fire) stall_cnt <= ((n_rsp % 300) < 60) ? 0 : $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (rsp_q.size() == 0) begin
        $error("result transfer with nothing expected");
        n_err++;
      end else begin
        mon_rsp = rsp_q.pop_front();
        n_rsp++;
        if (frame_address !== mon_rsp.addr) begin
          $error("frame_address: expected %h, got %h", mon_rsp.addr, frame_address);
          n_err++;
        end
        if (out_of_memory !== mon_rsp.oom) begin
          $error("out_of_memory: expected %b, got %b", mon_rsp.oom, out_of_memory);
          n_err++;
        end
        if (frame_count !== mon_rsp.count) begin
          $error("frame_count: expected %0d, got %0d", mon_rsp.count, frame_count);
          n_err++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    frame_cmd_t c;
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = FUNC_ALLOC;
    base_address = '0;
    length       = '0;
    out_stall    = 1'b0;
    in_fire      = 1'b0;
    out_fire     = 1'b0;
    gap_cnt      = 0;
    stall_cnt    = 0;
    hold_cnt     = 0;
    held         = 1'b0;
    n_err = 0; n_rsp = 0; n_alloc = 0; n_oom = 0; n_free = 0; n_range = 0; n_big = 0;
    for (int w = 0; w < N_WORDS; w++) used_map[w] = '1;
    water_mark = '0;

    // directed
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_FREE, 32'h0, 32'hFFFF_FFFF);
    push_cmd(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(FUNC_RANGE_FREE, 32'h0, 32'h0);
    push_cmd(FUNC_RANGE_FREE, 32'h1, 32'h2000);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_RANGE_FREE, 32'h1000, 32'h8000);
    push_cmd(FUNC_FREE, 32'h2ABC, 32'h0);
    push_cmd(FUNC_RANGE_USED, 32'h1001, 32'h1);
    push_cmd(FUNC_RANGE_USED, 32'h5000, 32'h0);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_FREE, 32'hFFFF_F000, 32'h0);
    push_cmd(FUNC_RANGE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(FUNC_RANGE_USED, 32'hFFFF_F000, 32'hFFFF_FFFF);
    push_cmd(FUNC_RANGE_FREE, 32'h0FFF_E000, 32'hFFFF_FFFF);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_RANGE_USED, 32'h0, 32'hFFFF_FFFF);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_RANGE_FREE, 32'h0, 32'h1000_0000);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);
    push_cmd(FUNC_FREE, 32'h0000_0FFF, 32'h0);
    push_cmd(FUNC_RANGE_USED, 32'h0010_0000, 32'h0010_0000);
    push_cmd(FUNC_ALLOC, 32'h0, 32'h0);

    // random
    for (int i = 0; i < 1850; i++) begin
      c = rand_cmd();
      if (op_cost(c) > BIG_COST && n_big >= BIG_LIMIT) begin
        c.func = FUNC_FREE;
        c.base = low_addr();
      end
      push_cmd(c.func, c.base, c.len);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || rsp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d results checked: %0d allocs (%0d out of memory), %0d frees, %0d range marks",
             n_rsp, n_alloc, n_oom, n_free, n_range);
    $display("%0d long scans or wide ranges, one long output hold-off", n_big);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
